FILE: rtl/core/cv3rb_pkg.sv
package cv3rb_pkg;

  localparam int MAX_W      = 1024;
  localparam int COL_W      = $clog2(MAX_W);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 16;
  localparam int ROW_W      = HGT_W + 1;
  localparam int SAMP_W     = 16;
  localparam int COEF_W     = 16;
  localparam int FRAC       = 12;
  localparam int KSIZE      = 3;
  localparam int PROD_W     = SAMP_W + COEF_W;
  localparam int PSUM_W     = PROD_W + 2;
  localparam int ACC_W      = PSUM_W + 2;
  localparam int OUT_W      = 24;
  localparam int KROW_W     = KSIZE * COEF_W;
  localparam int CFG_W      = KROW_W;
  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_KTOP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KMID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KBOT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DRAIN  = 1'b1;

  typedef logic signed [SAMP_W-1:0] samp_t;
  // element i is kernel row i (top, middle, bottom)
  typedef logic [KSIZE-1:0][SAMP_W-1:0] col_t;
  typedef logic [KSIZE-1:0][COEF_W-1:0] coef_col_t;

  typedef struct packed {
    samp_t top;
    samp_t mid;
  } ls_word_t;

  typedef struct packed {
    logic shift;
    logic load_all;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    eor;
    logic                    eof;
  } res_t;

endpackage

FILE: rtl/core/cv3rb_ram.sv
module cv3rb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/cv3rb_cell.sv
module cv3rb_cell import cv3rb_pkg::*; (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  col_t                     col_in,
  input  col_t                     col_load,
  input  col_t                     op_in,
  input  coef_col_t                coef,
  output col_t                     col_out,
  output logic signed [PSUM_W-1:0] psum
);

  col_t                     col_r, col_nxt;
  col_t                     op_r;
  logic signed [PROD_W-1:0] prod_r   [KSIZE];
  logic signed [PROD_W-1:0] prod_nxt [KSIZE];
  logic signed [PSUM_W-1:0] psum_r, psum_nxt;

  always_comb begin
    col_nxt = col_r;
    if (ctl.shift) begin
      col_nxt = ctl.load_all ? col_load : col_in;
    end
  end

  always_comb begin
    psum_nxt = '0;
    for (int i = 0; i < KSIZE; i++) begin
      prod_nxt[i] = $signed(op_r[i]) * $signed(coef[i]);
      psum_nxt    = psum_nxt + PSUM_W'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    col_r  <= col_nxt;
    op_r   <= op_in;
    prod_r <= prod_nxt;
    psum_r <= psum_nxt;
  end

  assign col_out = col_r;
  assign psum    = psum_r;

endmodule

FILE: rtl/core/cv3rb_ofifo.sv
module cv3rb_ofifo import cv3rb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_data,
  input  logic rd_en,
  output res_t rd_data,
  output logic empty
);

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign empty   = (count_r == '0);

endmodule

FILE: rtl/core/conv3x3_replicate_border.sv
// Streaming 3x3 convolution with edge-replicate borders. Takes one request per
// clock (sample or drain) unless stalled and gives the filtered pixel of row
// r-1 while row r streams in; the last pixel of each output row comes with the
// first request of the next row, and drain requests flush the final row. A
// result passes stage 1 and the cell operand, product and partial-sum registers
// into an 8-entry output queue; the input stalls only when that queue and the
// results still in the datapath reach 8, so with the output taken every clock
// the block sustains one request per clock. The two previous rows live in one
// 1024 x 32 RAM (write, registered read, same-address bypass), and the window
// is a row of three column cells, each with three 16x16 multipliers.
module conv3x3_replicate_border import cv3rb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic signed [SAMP_W-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_value,
  output logic                    out_end_of_row,
  output logic                    out_end_of_frame
);

  typedef struct packed {
    logic eor;
    logic eof;
  } tag_t;

  logic [KROW_W-1:0] ktop_r, kmid_r, kbot_r;
  logic [WID_W-1:0]  width_r;
  logic [HGT_W-1:0]  height_r;

  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic             fd_r, fd_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [ROW_W-1:0] h_ext;
  logic [ROW_W-1:0] row_c;
  logic [COL_W-1:0] col_c;
  logic [WID_W-1:0] col_inc;
  logic             is_samp, acc, pop;
  logic             do_adv, do_fin, adv_edge, adv_norm, res_any, wrap;

  // stage 1 (line store data back)
  logic             s1_adv_r, s1_res_r, s1_byp_r;
  logic             s1_edge_r, s1_col0_r, s1_row0_r, s1_drain_r;
  samp_t            s1_samp_r;
  logic [COL_W-1:0] s1_addr_r;
  tag_t             s1_tag_r;
  ls_word_t         byp_data_r;

  logic [2*SAMP_W-1:0] ram_rdata;
  ls_word_t            rd_word, wr_word;
  samp_t               top_s, mid_s, cur_s;
  col_t                vcol;
  logic                byp_nxt;

  logic v2_r, v3_r, v4_r;
  tag_t t2_r, t3_r, t4_r;

  cell_ctl_t                cell_ctl;
  col_t                     cell_col  [KSIZE];
  col_t                     cell_in   [KSIZE];
  col_t                     cell_op   [KSIZE];
  coef_col_t                cell_coef [KSIZE];
  logic signed [PSUM_W-1:0] cell_psum [KSIZE];
  logic [KROW_W-1:0]        krow      [KSIZE];

  logic signed [ACC_W-1:0] acc_sum, acc_q;
  localparam logic signed [ACC_W-1:0] VAL_MAX =
    {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] VAL_MIN =
    {{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
  res_t res_w, head;
  logic fifo_empty;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r   <= '0;
      kmid_r   <= KROW_W'(48'h0000_1000_0000);
      kbot_r   <= '0;
      width_r  <= WID_W'(MAX_W);
      height_r <= HGT_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KTOP:   ktop_r   <= cfg_data;
        REG_KMID:   kmid_r   <= cfg_data;
        REG_KBOT:   kbot_r   <= cfg_data;
        REG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(MAX_W)) begin
      w_eff = WID_W'(MAX_W);
    end
    h_eff = (height_r == '0) ? HGT_W'(1) : height_r;
    h_ext = {1'b0, h_eff};
  end

  // request decode
  assign in_stall = (cnt_r >= (PTR_W+1)'(FIFO_DEPTH));
  assign acc      = in_valid && !in_stall;
  assign is_samp  = (in_command == CMD_SAMPLE);

  always_comb begin
    row_c  = fd_r ? '0 : in_row_r;
    col_c  = fd_r ? '0 : in_col_r;
    do_adv = 1'b0;
    do_fin = 1'b0;
    if (is_samp) begin
      do_adv = (row_c < h_ext);
    end else if (!fd_r) begin
      if (in_row_r == h_ext) begin
        do_adv = 1'b1;
      end else if (in_row_r > h_ext) begin
        do_fin = 1'b1;
      end
    end
    adv_edge = do_adv && (col_c == '0) && (row_c >= ROW_W'(2));
    adv_norm = do_adv && (col_c != '0) && (row_c != '0);
    res_any  = adv_edge || adv_norm || do_fin;
    col_inc  = {1'b0, col_c} + WID_W'(1);
    wrap     = (col_inc >= w_eff);
  end

  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    fd_nxt     = fd_r;
    if (acc) begin
      if (is_samp) begin
        fd_nxt     = 1'b0;
        in_row_nxt = row_c;
        in_col_nxt = col_c;
      end
      if (do_adv) begin
        if (wrap) begin
          in_col_nxt = '0;
          in_row_nxt = row_c + ROW_W'(1);
        end else begin
          in_col_nxt = col_inc[COL_W-1:0];
        end
      end
      if (do_fin) begin
        fd_nxt = 1'b1;
      end
    end
  end

  assign pop     = out_valid && !out_stall;
  assign cnt_nxt = cnt_r + (PTR_W+1)'(acc && res_any) - (PTR_W+1)'(pop);
  assign byp_nxt = acc && s1_adv_r && (s1_addr_r == col_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
      fd_r     <= 1'b0;
      cnt_r    <= '0;
      s1_adv_r <= 1'b0;
      s1_res_r <= 1'b0;
      s1_byp_r <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
    end else begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
      fd_r     <= fd_nxt;
      cnt_r    <= cnt_nxt;
      s1_adv_r <= acc && do_adv;
      s1_res_r <= acc && res_any;
      s1_byp_r <= byp_nxt;
      v2_r     <= s1_res_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_edge_r    <= adv_edge || do_fin;
    s1_col0_r    <= (col_c == '0);
    s1_row0_r    <= (row_c == '0);
    s1_drain_r   <= !is_samp;
    s1_samp_r    <= in_sample;
    s1_addr_r    <= col_c;
    s1_tag_r.eor <= adv_edge || do_fin;
    s1_tag_r.eof <= do_fin;
    byp_data_r   <= wr_word;
    t2_r         <= s1_tag_r;
    t3_r         <= t2_r;
    t4_r         <= t3_r;
  end

  // line store: top word is the row two up, mid word the row above
  cv3rb_ram #(
    .WIDTH ($bits(ls_word_t)),
    .DEPTH (MAX_W)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv_r),
    .waddr (s1_addr_r),
    .wdata (wr_word),
    .re    (acc && do_adv),
    .raddr (col_c),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_word     = s1_byp_r ? byp_data_r : ls_word_t'(ram_rdata);
    top_s       = s1_row0_r ? s1_samp_r : rd_word.top;
    mid_s       = s1_row0_r ? s1_samp_r : rd_word.mid;
    cur_s       = s1_drain_r ? rd_word.mid : s1_samp_r;
    wr_word.top = mid_s;
    wr_word.mid = cur_s;
    vcol[0]     = top_s;
    vcol[1]     = mid_s;
    vcol[2]     = cur_s;
  end

  // window: three column cells, shifting left
  assign cell_ctl.shift    = s1_adv_r;
  assign cell_ctl.load_all = s1_col0_r;
  assign krow[0] = ktop_r;
  assign krow[1] = kmid_r;
  assign krow[2] = kbot_r;

  for (genvar j = 0; j < KSIZE; j++) begin : g_cells
    if (j == KSIZE - 1) begin : g_last
      // border result uses the old right column twice
      assign cell_in[j] = vcol;
      assign cell_op[j] = s1_edge_r ? cell_col[j] : vcol;
    end else begin : g_mid
      assign cell_in[j] = cell_col[j+1];
      assign cell_op[j] = cell_col[j+1];
    end
    for (genvar i = 0; i < KSIZE; i++) begin : g_coef
      assign cell_coef[j][i] = krow[i][j*COEF_W +: COEF_W];
    end
    cv3rb_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .col_in   (cell_in[j]),
      .col_load (vcol),
      .op_in    (cell_op[j]),
      .coef     (cell_coef[j]),
      .col_out  (cell_col[j]),
      .psum     (cell_psum[j])
    );
  end

  // final sum, floor shift, saturate
  always_comb begin
    acc_sum = ACC_W'(cell_psum[0]) + ACC_W'(cell_psum[1]) + ACC_W'(cell_psum[2]);
    acc_q   = acc_sum >>> FRAC;
    if (acc_q > VAL_MAX) begin
      res_w.value = VAL_MAX[OUT_W-1:0];
    end else if (acc_q < VAL_MIN) begin
      res_w.value = VAL_MIN[OUT_W-1:0];
    end else begin
      res_w.value = acc_q[OUT_W-1:0];
    end
    res_w.eor = t4_r.eor;
    res_w.eof = t4_r.eof;
  end

  cv3rb_ofifo u_ofifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (v4_r),
    .wr_data (res_w),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (fifo_empty)
  );

  assign out_valid        = !fifo_empty;
  assign out_value        = head.value;
  assign out_end_of_row   = head.eor;
  assign out_end_of_frame = head.eof;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PTR_W+1)'(FIFO_DEPTH))
    else $error("result credit count above queue depth");

  a_bypass_src: assert property (@(posedge clk) disable iff (!rst_n)
    s1_byp_r |-> $past(s1_adv_r))
    else $error("line store bypass without a write");

  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    acc && do_fin |=> fd_r)
    else $error("final drain did not close the frame");

  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_end_of_row)
    else $error("frame end without row end");

endmodule

FILE: dv/tb_top.sv
module tb_top import cv3rb_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_WIDTH = 16;

  typedef enum int {FRAME_PLAIN, FRAME_PAUSE, FRAME_HOLD} frame_mode_e;

  class conv_scoreboard;
    logic [KROW_W-1:0] kernel_rows[KSIZE];
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    samp_t upper_line[MAX_W];
    samp_t lower_line[MAX_W];
    samp_t win[KSIZE][KSIZE];
    int unsigned row_in;
    int unsigned col_in;
    bit frame_done;
    res_t pending_pixels[$];
    int errors;

    function new();
      kernel_rows[0] = '0;
      kernel_rows[1] = KROW_W'(48'h0000_1000_0000);
      kernel_rows[2] = '0;
      width_reg = WID_W'(1024);
      height_reg = HGT_W'(1024);
      foreach (win[i, j]) win[i][j] = '0;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      row_in = 0;
      col_in = 0;
      frame_done = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_KTOP:   kernel_rows[0] = data;
        REG_KMID:   kernel_rows[1] = data;
        REG_KBOT:   kernel_rows[2] = data;
        REG_WIDTH:  width_reg = data[WID_W-1:0];
        REG_HEIGHT: height_reg = data[HGT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      return w;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function logic signed [OUT_W-1:0] weighted_sum(int lc, int cc, int rc);
      longint acc;
      int cols[KSIZE];
      cols[0] = lc;
      cols[1] = cc;
      cols[2] = rc;
      acc = 0;
      for (int i = 0; i < KSIZE; i++)
        for (int j = 0; j < KSIZE; j++)
          acc += longint'($signed(kernel_rows[i][COEF_W*j +: COEF_W])) *
                 longint'(win[i][cols[j]]);
      acc = acc >>> FRAC;
      if (acc > 64'sd8388607) acc = 64'sd8388607;
      if (acc < -64'sd8388608) acc = -64'sd8388608;
      return acc[OUT_W-1:0];
    endfunction

    function void shift_in(samp_t s);
      int unsigned c;
      samp_t top, mid, v;
      res_t r;
      bit got;
      c = (col_in < MAX_W) ? col_in : MAX_W - 1;
      got = 0;
      // right edge of the row two rows up, right column repeated
      if (col_in == 0 && row_in >= 2) begin
        r.value = weighted_sum(1, 2, 2);
        r.eor = 1'b1;
        r.eof = 1'b0;
        pending_pixels.push_back(r);
        got = 1;
      end
      top = (row_in == 0) ? s : upper_line[c];
      mid = (row_in == 0) ? s : lower_line[c];
      upper_line[c] = mid;
      lower_line[c] = s;
      for (int i = 0; i < KSIZE; i++) begin
        v = (i == 0) ? top : (i == 1) ? mid : s;
        if (col_in == 0) begin
          win[i][0] = v;
          win[i][1] = v;
        end else begin
          win[i][0] = win[i][1];
          win[i][1] = win[i][2];
        end
        win[i][2] = v;
      end
      if (col_in >= 1 && row_in >= 1 && !got) begin
        r.value = weighted_sum(0, 1, 2);
        r.eor = 1'b0;
        r.eof = 1'b0;
        pending_pixels.push_back(r);
      end
      col_in++;
      if (col_in >= eff_width()) begin
        col_in = 0;
        row_in++;
      end
    endfunction

    function void note_request(logic cmd, samp_t pix);
      int unsigned h;
      res_t r;
      h = eff_height();
      if (cmd == CMD_SAMPLE) begin
        if (frame_done) begin
          row_in = 0;
          col_in = 0;
          frame_done = 0;
        end
        if (row_in < h) shift_in(pix);
      end else if (!frame_done && row_in >= h) begin
        if (row_in == h) begin
          shift_in(lower_line[(col_in < MAX_W) ? col_in : MAX_W - 1]);
        end else begin
          r.value = weighted_sum(1, 2, 2);
          r.eor = 1'b1;
          r.eof = 1'b1;
          pending_pixels.push_back(r);
          frame_done = 1;
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [OUT_W-1:0] value, logic eor, logic eof);
      res_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel value=%0d", value));
        return;
      end
      want = pending_pixels.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("value %0d, want %0d", value, want.value));
      if (eor !== want.eor)
        report_mismatch($sformatf("end_of_row %b, want %b", eor, want.eor));
      if (eof !== want.eof)
        report_mismatch($sformatf("end_of_frame %b, want %b", eof, want.eof));
    endtask

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KTOP;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = CMD_SAMPLE;
  logic signed [SAMP_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] out_value;
  logic out_end_of_row;
  logic out_end_of_frame;

  int gap_pct = 0;
  int stall_pct = 0;
  logic hold_on = 1'b0;
  int unsigned cycle_count = 0;
  conv_scoreboard sb = new();

  conv3x3_replicate_border uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_command(in_command),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_end_of_row(out_end_of_row),
    .out_end_of_frame(out_end_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_command, in_sample);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_value, out_end_of_row, out_end_of_frame);
  end

  function automatic samp_t random_pixel();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return samp_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_kernel_row();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[CFG_W-1:0];
  endfunction

  task automatic send_request(logic cmd, samp_t pix);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sample <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic setup_frame(int w, int h);
    write_reg(REG_KTOP, random_kernel_row());
    write_reg(REG_KMID, random_kernel_row());
    write_reg(REG_KBOT, random_kernel_row());
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
  endtask

  // noise: early drains, samples during the flush, a drain after the frame
  task automatic run_frame(int w, int h, int noise_pct, frame_mode_e mode);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if (r == 1 && c == 0) begin
          if (mode == FRAME_PAUSE) wait_drained();
          if (mode == FRAME_HOLD) begin
            fork
              begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
              end
            join_none
          end
        end
        if ($urandom_range(0, 99) < noise_pct) send_request(CMD_DRAIN, random_pixel());
        send_request(CMD_SAMPLE, random_pixel());
      end
    end
    for (int d = 0; d <= w; d++) begin
      if ($urandom_range(0, 99) < noise_pct) send_request(CMD_SAMPLE, random_pixel());
      send_request(CMD_DRAIN, random_pixel());
    end
    if ($urandom_range(0, 99) < noise_pct) send_request(CMD_DRAIN, random_pixel());
  endtask

  initial begin
    int gap_set[4];
    int stall_set[4];
    gap_set = '{0, 45, 0, 12};
    stall_set = '{0, 0, 45, 12};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_KTOP, {16'h7FFF, 16'h8000, 16'h1000});
    write_reg(REG_KMID, {16'h0000, 16'hFFFF, 16'h7FFF});
    write_reg(REG_KBOT, {16'h8000, 16'h0001, 16'hF000});
    write_reg(REG_WIDTH, CFG_W'(2));
    write_reg(REG_HEIGHT, CFG_W'(2));
    send_request(CMD_DRAIN, 16'sh0000);
    send_request(CMD_SAMPLE, 16'sh7FFF);
    send_request(CMD_SAMPLE, 16'sh8000);
    send_request(CMD_SAMPLE, -16'sd1);
    send_request(CMD_SAMPLE, 16'sh0000);
    send_request(CMD_SAMPLE, 16'sh1234);
    repeat (3) send_request(CMD_DRAIN, 16'sh5555);
    send_request(CMD_DRAIN, 16'shAAAA);
    repeat (4) send_request(CMD_SAMPLE, 16'sh8000);
    repeat (3) send_request(CMD_DRAIN, 16'sh0000);

    wait_idle();
    write_reg(REG_KTOP, {3{16'h8000}});
    write_reg(REG_KMID, {3{16'h8000}});
    write_reg(REG_KBOT, {3{16'h8000}});
    write_reg(REG_WIDTH, CFG_W'(3));
    repeat (6) send_request(CMD_SAMPLE, 16'sh8000);
    repeat (4) send_request(CMD_DRAIN, 16'sh7FFF);

    for (int p = 0; p < 4; p++) begin
      gap_pct = gap_set[p];
      stall_pct = stall_set[p];
      for (int f = 0; f < 4; f++) begin
        int w;
        int h;
        w = $urandom_range(2, 7);
        h = $urandom_range(2, 4);
        wait_idle();
        setup_frame(w, h);
        run_frame(w, h, 10, (p == 1 && f == 0) ? FRAME_PAUSE : FRAME_PLAIN);
      end
    end

    // long output hold-off fills the block
    wait_idle();
    gap_pct = 0;
    stall_pct = 12;
    setup_frame(HOLD_WIDTH, 2);
    run_frame(HOLD_WIDTH, 2, 0, FRAME_HOLD);

    // tallest frame, left unfinished
    wait_idle();
    gap_pct = 12;
    setup_frame(2, 65535);
    repeat (20) send_request(CMD_SAMPLE, random_pixel());

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cv3rb_pkg.sv
rtl/core/cv3rb_ram.sv
rtl/core/cv3rb_cell.sv
rtl/core/cv3rb_ofifo.sv
rtl/core/conv3x3_replicate_border.sv
dv/tb_top.sv
